// ===== sv/plom_pkg.sv =====
// Shared types and constants of the price level order matcher.
`default_nettype none
package plom_pkg;

    localparam int unsigned DEPTH_W = 32;
    localparam int unsigned QTY_W   = 16;
    localparam int unsigned VOL_W   = 40;
    localparam int unsigned PRICE_W = 10;
    localparam int unsigned ASK_W   = 11;
    localparam int unsigned CMP_W   = 21;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MATCH,
        S_MATCH_UPD,
        S_REST,
        S_REST_UPD,
        S_ASK,
        S_ASK_CHK,
        S_BID,
        S_BID_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic fill;
    } t_bar_ctl;

endpackage
`default_nettype wire

// ===== sv/price_level_order_matcher_core.sv =====
// Top level of the price level order matcher: sequencer, book memories and result register.
// The block holds an aggregate resting quantity for every price level of both sides in two
// memories, and each request is one order that is worked through by a small sequencer which
// visits one price level at a time while matching, reading the level and then updating it.
// After reset the block first sweeps both memories to zero, one level after another, with
// ready low. An order is then taken in idle, and the walk reads and updates each level
// while matching and then ends. Next the resting level is read and a limit remainder is
// rested; each best price is moved outward over empty levels and then confirmed; finally
// the result is loaded, held for as long as the previous result still waits. The cost
// therefore depends on how sparse the book is near the touch. Ready is low for the whole
// of an order; a finished result waits in the output register while the next order is
// accepted. A limit order priced at or above PRICE_LEVELS is ignored and reports the
// unchanged book. Level zero is never matched.
`default_nettype none
module price_level_order_matcher_core
    import plom_pkg::*;
#(
    parameter int unsigned PRICE_LEVELS = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_new_bar,
    input  wire logic                 i_side,
    input  wire logic                 i_order_kind,
    input  wire logic [PRICE_W-1:0]   i_limit_price,
    input  wire logic [QTY_W-1:0]     i_quantity,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic      [QTY_W-1:0]     o_filled_qty,
    output logic      [QTY_W-1:0]     o_rested_qty,
    output logic      [PRICE_W-1:0]   o_best_bid,
    output logic      [ASK_W-1:0]     o_best_ask,
    output logic      [PRICE_W-1:0]   o_bar_open,
    output logic      [PRICE_W-1:0]   o_bar_high,
    output logic      [PRICE_W-1:0]   o_bar_low,
    output logic      [PRICE_W-1:0]   o_bar_close,
    output logic      [VOL_W-1:0]     o_bar_volume,
    output logic                      o_bar_any_trade
);
    localparam int unsigned AW = $clog2(PRICE_LEVELS);
    localparam int unsigned LW = AW + 1;
    localparam logic [CMP_W-1:0] PL_CMP = CMP_W'(PRICE_LEVELS);

    t_state r_state, n_state;

    logic [AW-1:0]      r_clr_cnt, n_clr_cnt;
    logic               r_is_sell, n_is_sell;
    logic               r_is_market, n_is_market;
    logic [PRICE_W-1:0] r_limit, n_limit;
    logic [QTY_W-1:0]   r_remaining, n_remaining;
    logic [QTY_W-1:0]   r_filled, n_filled;
    logic [QTY_W-1:0]   r_rested, n_rested;
    logic [LW-1:0]      r_level, n_level;
    logic [LW-1:0]      r_best_ask, n_best_ask;
    logic [LW-1:0]      r_best_bid, n_best_bid;
    logic               r_out_valid;

    // Memory ports, shared by both sides; the write enable picks the side.
    logic               ask_we, bid_we;
    logic [AW-1:0]      waddr, raddr;
    logic [DEPTH_W-1:0] wdata, ask_rdata, bid_rdata;

    t_bar_ctl           bar_ctl;
    logic [QTY_W-1:0]   bar_qty;
    logic [AW-1:0]      bar_open, bar_high, bar_low, bar_close;
    logic [VOL_W-1:0]   bar_volume;
    logic               bar_has;

    logic               accept;
    logic               in_range;
    logic               match_stop;
    logic [DEPTH_W-1:0] match_data, own_data;
    logic [QTY_W-1:0]   take;
    logic [DEPTH_W:0]   rest_sum;
    logic               out_free;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign in_range = CMP_W'(i_limit_price) < PL_CMP;
    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;

    // The walk ends when the order is filled, at the edge of the book, or past the limit.
    assign match_stop = (r_remaining == '0) || (r_level == '0) ||
                        (CMP_W'(r_level) >= PL_CMP) ||
                        (!r_is_market && !r_is_sell && CMP_W'(r_level) > CMP_W'(r_limit)) ||
                        (!r_is_market && r_is_sell && CMP_W'(r_level) < CMP_W'(r_limit));

    assign match_data = r_is_sell ? bid_rdata : ask_rdata;
    assign own_data   = r_is_sell ? ask_rdata : bid_rdata;
    assign take       = (match_data >= DEPTH_W'(r_remaining)) ? r_remaining
                                                                : match_data[QTY_W-1:0];
    assign rest_sum   = {1'b0, own_data} + (DEPTH_W + 1)'(r_remaining);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == AW'(PRICE_LEVELS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_order_kind || in_range) ? S_MATCH : S_DONE;
                end
            end
            S_MATCH:     n_state = match_stop ? S_REST : S_MATCH_UPD;
            S_MATCH_UPD: n_state = S_MATCH;
            S_REST: begin
                n_state = (!r_is_market && r_remaining != '0) ? S_REST_UPD : S_ASK;
            end
            S_REST_UPD:  n_state = S_ASK;
            S_ASK:       n_state = (CMP_W'(r_best_ask) >= PL_CMP) ? S_BID : S_ASK_CHK;
            S_ASK_CHK:   n_state = (ask_rdata == '0) ? S_ASK : S_BID;
            S_BID:       n_state = (r_best_bid == '0) ? S_DONE : S_BID_CHK;
            S_BID_CHK:   n_state = (bid_rdata == '0) ? S_BID : S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_CLEAR;
        endcase
    end

    // Datapath and memory control for each state.
    always_comb begin
        n_clr_cnt   = r_clr_cnt;
        n_is_sell   = r_is_sell;
        n_is_market = r_is_market;
        n_limit     = r_limit;
        n_remaining = r_remaining;
        n_filled    = r_filled;
        n_rested    = r_rested;
        n_level     = r_level;
        n_best_ask  = r_best_ask;
        n_best_bid  = r_best_bid;
        ask_we      = 1'b0;
        bid_we      = 1'b0;
        waddr       = r_level[AW-1:0];
        wdata       = '0;
        raddr       = r_level[AW-1:0];
        bar_ctl     = '0;
        bar_qty     = take;
        unique case (r_state)
            S_CLEAR: begin
                ask_we    = 1'b1;
                bid_we    = 1'b1;
                waddr     = r_clr_cnt;
                n_clr_cnt = r_clr_cnt + 1'b1;
            end
            S_IDLE: begin
                if (accept) begin
                    bar_ctl.clear = i_new_bar;
                    n_is_sell     = i_side;
                    n_is_market   = i_order_kind;
                    n_limit       = i_limit_price;
                    n_remaining   = i_quantity;
                    n_filled      = '0;
                    n_rested      = '0;
                    n_level       = i_side ? r_best_bid : r_best_ask;
                end
            end
            S_MATCH: begin
                raddr = r_level[AW-1:0];
            end
            S_MATCH_UPD: begin
                if (match_data != '0) begin
                    ask_we       = !r_is_sell;
                    bid_we       = r_is_sell;
                    wdata        = match_data - DEPTH_W'(take);
                    n_remaining  = r_remaining - take;
                    n_filled     = r_filled + take;
                    bar_ctl.fill = 1'b1;
                end
                n_level = r_is_sell ? r_level - 1'b1 : r_level + 1'b1;
            end
            S_REST: begin
                raddr = AW'(r_limit);
            end
            S_REST_UPD: begin
                ask_we   = r_is_sell;
                bid_we   = !r_is_sell;
                waddr    = AW'(r_limit);
                wdata    = rest_sum[DEPTH_W] ? '1 : rest_sum[DEPTH_W-1:0];
                n_rested = r_remaining;
                if (!r_is_sell) begin
                    if (r_best_bid == '0 || CMP_W'(r_limit) > CMP_W'(r_best_bid)) begin
                        n_best_bid = LW'(r_limit);
                    end
                end else begin
                    if (CMP_W'(r_best_ask) == PL_CMP ||
                        CMP_W'(r_limit) < CMP_W'(r_best_ask)) begin
                        n_best_ask = LW'(r_limit);
                    end
                end
            end
            S_ASK: begin
                raddr = r_best_ask[AW-1:0];
            end
            S_ASK_CHK: begin
                if (ask_rdata == '0) begin
                    n_best_ask = r_best_ask + 1'b1;
                end
            end
            S_BID: begin
                raddr = r_best_bid[AW-1:0];
            end
            S_BID_CHK: begin
                if (bid_rdata == '0) begin
                    n_best_bid = r_best_bid - 1'b1;
                end
            end
            S_DONE: begin
                raddr = r_level[AW-1:0];
            end
            default: begin
                raddr = r_level[AW-1:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_best_ask  <= LW'(PRICE_LEVELS);
            r_best_bid  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_cnt  <= n_clr_cnt;
            r_best_ask <= n_best_ask;
            r_best_bid <= n_best_bid;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_sell   <= n_is_sell;
        r_is_market <= n_is_market;
        r_limit     <= n_limit;
        r_remaining <= n_remaining;
        r_filled    <= n_filled;
        r_rested    <= n_rested;
        r_level     <= n_level;
        if (r_state == S_DONE && out_free) begin
            o_filled_qty    <= r_filled;
            o_rested_qty    <= r_rested;
            o_best_bid      <= PRICE_W'(r_best_bid);
            o_best_ask      <= ASK_W'(r_best_ask);
            o_bar_open      <= PRICE_W'(bar_open);
            o_bar_high      <= PRICE_W'(bar_high);
            o_bar_low       <= PRICE_W'(bar_low);
            o_bar_close     <= PRICE_W'(bar_close);
            o_bar_volume    <= bar_volume;
            o_bar_any_trade <= bar_has;
        end
    end

    plom_ram #(.DEPTH(PRICE_LEVELS), .WIDTH(DEPTH_W)) u_ask_ram (
        .i_clk   (i_clk),
        .i_we    (ask_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (ask_rdata)
    );

    plom_ram #(.DEPTH(PRICE_LEVELS), .WIDTH(DEPTH_W)) u_bid_ram (
        .i_clk   (i_clk),
        .i_we    (bid_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (bid_rdata)
    );

    plom_bar #(.AW(AW)) u_bar (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (bar_ctl),
        .i_level     (r_level[AW-1:0]),
        .i_qty       (bar_qty),
        .o_open      (bar_open),
        .o_high      (bar_high),
        .o_low       (bar_low),
        .o_close     (bar_close),
        .o_volume    (bar_volume),
        .o_has_trade (bar_has)
    );
endmodule
`default_nettype wire

// ===== sv/plom_ram.sv =====
// Single write port, single registered read port depth memory.
`default_nettype none
module plom_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/plom_bar.sv =====
// OHLCV bar registers with saturating volume accumulation.
`default_nettype none
module plom_bar
    import plom_pkg::*;
#(
    parameter int unsigned AW = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_bar_ctl           i_ctl,
    input  wire logic [AW-1:0]      i_level,
    input  wire logic [QTY_W-1:0]   i_qty,
    output logic      [AW-1:0]      o_open,
    output logic      [AW-1:0]      o_high,
    output logic      [AW-1:0]      o_low,
    output logic      [AW-1:0]      o_close,
    output logic      [VOL_W-1:0]   o_volume,
    output logic                    o_has_trade
);
    logic [VOL_W:0] n_sum;

    assign n_sum = {1'b0, o_volume} + (VOL_W + 1)'(i_qty);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            o_open      <= '0;
            o_high      <= '0;
            o_low       <= '0;
            o_close     <= '0;
            o_volume    <= '0;
            o_has_trade <= 1'b0;
        end else if (i_ctl.fill) begin
            if (!o_has_trade) begin
                o_open      <= i_level;
                o_high      <= i_level;
                o_low       <= i_level;
                o_close     <= i_level;
                o_volume    <= VOL_W'(i_qty);
                o_has_trade <= 1'b1;
            end else begin
                if (i_level > o_high) begin
                    o_high <= i_level;
                end
                if (i_level < o_low) begin
                    o_low <= i_level;
                end
                o_close  <= i_level;
                o_volume <= n_sum[VOL_W] ? '1 : n_sum[VOL_W-1:0];
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/plom_checker.sv =====
// Port level checks of the price level order matcher and their binding.
`default_nettype none
module plom_checker
    import plom_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               o_ready,
    input  wire logic               o_valid,
    input  wire logic               i_ready,
    input  wire logic [PRICE_W-1:0] o_bar_high,
    input  wire logic [PRICE_W-1:0] o_bar_low,
    input  wire logic [VOL_W-1:0]   o_bar_volume,
    input  wire logic               o_bar_any_trade
);
    // A result is held until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped before it was taken");

    // One order at a time: ready falls once a request is taken.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second request accepted while an order is in work");

    // An empty bar reports no volume.
    a_empty_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_bar_any_trade |-> o_bar_volume == '0)
        else $error("volume reported for a bar without trades");

    // The bar low never lies above the bar high.
    a_low_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bar_any_trade |-> o_bar_low <= o_bar_high)
        else $error("bar low above bar high");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");
endmodule

bind price_level_order_matcher_core plom_checker u_plom_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_bar_high      (o_bar_high),
    .o_bar_low       (o_bar_low),
    .o_bar_volume    (o_bar_volume),
    .o_bar_any_trade (o_bar_any_trade)
);
`default_nettype wire
